FILE: sv/lfu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lfu page replacement block
// no dependencies

package lfu_pkg;

    // fixed field widths
    localparam int FAULT_W = 32;
    localparam int SLOT_W  = 3;
    localparam int FIU_W   = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register map
    localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = 3'd0;
    localparam logic [FIU_W-1:0]  FIU_RESET          = 4'd8;

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    // flags carried along the scan chain
    typedef struct packed {
        logic hit;
        logic empty;
    } t_scan_flags;

    // write-back command to one cell
    typedef struct packed {
        logic en;
        logic hit;
    } t_wr_cmd;

endpackage

FILE: sv/lfu_cell.sv
`timescale 1ns / 1ps
// one frame cell: holds page, occupied flag and use count, folds itself
// into the scan word handed down the chain; depends on lfu_pkg

module lfu_cell
    import lfu_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int IDX_W      = 3,
    parameter int CNT_W      = 4,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [PAGE_BITS-1:0]  i_key,
    input  logic [CNT_W-1:0]      i_n_active,
    input  t_wr_cmd               i_wr,
    input  t_scan_flags           i_flags,
    input  logic [IDX_W-1:0]      i_hit_idx,
    input  logic [IDX_W-1:0]      i_empty_idx,
    input  logic [COUNT_BITS-1:0] i_best_cnt,
    input  logic [IDX_W-1:0]      i_best_idx,
    input  logic [PAGE_BITS-1:0]  i_best_page,
    output t_scan_flags           o_flags,
    output logic [IDX_W-1:0]      o_hit_idx,
    output logic [IDX_W-1:0]      o_empty_idx,
    output logic [COUNT_BITS-1:0] o_best_cnt,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [PAGE_BITS-1:0]  o_best_page
);

    localparam bit                    IS_FIRST = (IDX == 0);
    localparam logic [IDX_W-1:0]      MY_IDX   = IDX_W'(IDX);
    localparam logic [CNT_W-1:0]      MY_POS   = CNT_W'(IDX);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_occ;
    logic [COUNT_BITS-1:0] r_count;

    t_scan_flags           r_flags, n_flags;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]      r_empty_idx, n_empty_idx;
    logic [COUNT_BITS-1:0] r_best_cnt, n_best_cnt;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [PAGE_BITS-1:0]  r_best_page, n_best_page;

    logic w_active;

    assign w_active = (MY_POS < i_n_active);

    // fold this frame into the incoming scan word
    always_comb begin
        n_flags     = i_flags;
        n_hit_idx   = i_hit_idx;
        n_empty_idx = i_empty_idx;
        n_best_cnt  = i_best_cnt;
        n_best_idx  = i_best_idx;
        n_best_page = i_best_page;
        if (w_active) begin
            if (!i_flags.hit && r_occ && (r_page == i_key)) begin
                n_flags.hit = 1'b1;
                n_hit_idx   = MY_IDX;
            end
            if (!i_flags.empty && !r_occ) begin
                n_flags.empty = 1'b1;
                n_empty_idx   = MY_IDX;
            end
            if (IS_FIRST || (r_count < i_best_cnt)) begin
                n_best_cnt  = r_count;
                n_best_idx  = MY_IDX;
                n_best_page = r_page;
            end
        end
    end

    // scan word to the next cell
    always_ff @(posedge i_clk) begin
        r_flags     <= n_flags;
        r_hit_idx   <= n_hit_idx;
        r_empty_idx <= n_empty_idx;
        r_best_cnt  <= n_best_cnt;
        r_best_idx  <= n_best_idx;
        r_best_page <= n_best_page;
    end

    // frame contents, updated on write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_count <= '0;
        end else if (i_wr.en) begin
            if (i_wr.hit) begin
                if (r_count != CNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end else begin
                r_occ   <= 1'b1;
                r_count <= COUNT_BITS'(1);
            end
        end
    end

    // page tag needs no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.hit) begin
            r_page <= i_key;
        end
    end

    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_best_cnt  = r_best_cnt;
    assign o_best_idx  = r_best_idx;
    assign o_best_page = r_best_page;

endmodule

FILE: sv/lfu_page_replacement_top.sv
`timescale 1ns / 1ps
// top level of the lfu page replacement block: sequencer, config register
// and the chain of frame cells; depends on lfu_pkg and lfu_cell
//
// usage
//   command channel: drive i_page_number with start high; the word is taken
//   at the edge where start is high and busy is low. busy stays high until
//   the result has been written back.
//   result channel: o_valid is high for one cycle with o_hit, o_slot,
//   o_evicted_valid, o_evicted_page and o_fault_total. there is no stall.
//   config: APB register frames_in_use at address 0 (reset 8); write it only
//   while busy is low. 0 acts as 1, values above MAX_FRAMES as MAX_FRAMES.
//   timing: the scan word walks the cell chain one frame per cycle through
//   the register in each cell; the done state then takes the decision and
//   does the write-back, and the result is registered onto the ports. start
//   can be accepted again at the edge that ends the o_valid cycle, so a new
//   word is taken only after the last one's result is out.
//   reset: synchronous, active low; all frames empty, fault count zero.

module lfu_page_replacement_top
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_total,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_FRAMES - 1);
    localparam logic [CNT_W-1:0] N_MAX     = CNT_W'(MAX_FRAMES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_scan_cnt;
    logic [PAGE_BITS-1:0] r_key;
    logic [CNT_W-1:0]     r_n_active;
    logic [FIU_W-1:0]     r_fiu;
    logic [FAULT_W-1:0]   r_fault;
    logic [CNT_W-1:0]     w_n_active;
    logic                 w_accept;

    // chain wiring: position j feeds cell j
    t_scan_flags           c_flags     [MAX_FRAMES+1];
    logic [IDX_W-1:0]      c_hit_idx   [MAX_FRAMES+1];
    logic [IDX_W-1:0]      c_empty_idx [MAX_FRAMES+1];
    logic [COUNT_BITS-1:0] c_best_cnt  [MAX_FRAMES+1];
    logic [IDX_W-1:0]      c_best_idx  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0]  c_best_page [MAX_FRAMES+1];
    t_wr_cmd               w_wr        [MAX_FRAMES];

    t_scan_flags          w_end_flags;
    logic [IDX_W-1:0]     w_sel_idx;
    logic                 w_evict;

    logic                 r_valid;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // config register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu <= FIU_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_FRAMES_IN_USE[2])) begin
            r_fiu <= pwdata[FIU_W-1:0];
        end
    end
    assign prdata = (paddr[2] == ADDR_FRAMES_IN_USE[2]) ? APB_DW'(r_fiu) : '0;

    // clamp the frame count into 1..MAX_FRAMES
    always_comb begin
        priority if (r_fiu == '0) begin
            w_n_active = CNT_W'(1);
        end else if (7'(r_fiu) > 7'(MAX_FRAMES)) begin
            w_n_active = N_MAX;
        end else begin
            w_n_active = CNT_W'(r_fiu);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_SCAN;
            ST_SCAN: if (r_scan_cnt == SCAN_LAST) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end else begin
                r_scan_cnt <= '0;
            end
        end
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key      <= i_page_number;
            r_n_active <= w_n_active;
        end
    end

    // head of the chain
    assign c_flags[0]     = '0;
    assign c_hit_idx[0]   = '0;
    assign c_empty_idx[0] = '0;
    assign c_best_cnt[0]  = '0;
    assign c_best_idx[0]  = '0;
    assign c_best_page[0] = '0;

    // decision from the tail of the chain
    assign w_end_flags = c_flags[MAX_FRAMES];
    assign w_evict     = !w_end_flags.hit && !w_end_flags.empty;
    always_comb begin
        priority if (w_end_flags.hit) begin
            w_sel_idx = c_hit_idx[MAX_FRAMES];
        end else if (w_end_flags.empty) begin
            w_sel_idx = c_empty_idx[MAX_FRAMES];
        end else begin
            w_sel_idx = c_best_idx[MAX_FRAMES];
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_FRAMES; j++) begin : g_cell
            assign w_wr[j].en  = (r_state == ST_DONE) && (w_sel_idx == IDX_W'(j));
            assign w_wr[j].hit = w_end_flags.hit;

            lfu_cell #(
                .IDX        (j),
                .IDX_W      (IDX_W),
                .CNT_W      (CNT_W),
                .PAGE_BITS  (PAGE_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_key       (r_key),
                .i_n_active  (r_n_active),
                .i_wr        (w_wr[j]),
                .i_flags     (c_flags[j]),
                .i_hit_idx   (c_hit_idx[j]),
                .i_empty_idx (c_empty_idx[j]),
                .i_best_cnt  (c_best_cnt[j]),
                .i_best_idx  (c_best_idx[j]),
                .i_best_page (c_best_page[j]),
                .o_flags     (c_flags[j+1]),
                .o_hit_idx   (c_hit_idx[j+1]),
                .o_empty_idx (c_empty_idx[j+1]),
                .o_best_cnt  (c_best_cnt[j+1]),
                .o_best_idx  (c_best_idx[j+1]),
                .o_best_page (c_best_page[j+1])
            );
        end
    endgenerate

    // fault counter, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if ((r_state == ST_DONE) && !w_end_flags.hit && (r_fault != FAULT_MAX)) begin
            r_fault <= r_fault + 1'b1;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_DONE);
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_hit      <= w_end_flags.hit;
            r_slot     <= SLOT_W'(w_sel_idx);
            r_ev_valid <= w_evict;
            r_ev_page  <= w_evict ? c_best_page[MAX_FRAMES] : '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault;

endmodule

FILE: sv/lfu_checker.sv
`timescale 1ns / 1ps
// port-level checks for the lfu page replacement block, bound to the top
// level; depends on lfu_pkg and lfu_page_replacement_top

module lfu_checker
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic                 o_hit,
    input logic                 o_evicted_valid,
    input logic [PAGE_BITS-1:0] o_evicted_page
);

    // busy is raised once a word is accepted
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // fixed latency from accept to result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##(MAX_FRAMES + 2) o_valid)
        else $error("result missing after scan latency");

    // result shows only as the block goes idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe outside end of work");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // evicted page is zero without an eviction
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted_valid |-> (o_evicted_page == '0))
        else $error("evicted page not zero");

endmodule

bind lfu_page_replacement_top lfu_checker #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
) u_lfu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page)
);

FILE: bench/lfu_page_replacement_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for lfu_page_replacement_top: page references with random
// bursts and gaps, frames_in_use writes over APB, every result word predicted
// and compared; depends on lfu_pkg and the block's rtl

module lfu_page_replacement_top_test;
    import lfu_pkg::*;

    localparam int MAX_FRAMES  = 8;
    localparam int PAGE_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int WORD_CYCLES = MAX_FRAMES + 2;
    localparam longint CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_REFS  = 75;
    // byte address of register index 1, which does not exist
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = ADDR_FRAMES_IN_USE + 3'd4;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        page_t              evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } outcome_t;

    // frame table mirror plus the queue of outcomes still to arrive
    class lfu_ref_tracker;
        page_t              resident [MAX_FRAMES];
        bit                 occupied [MAX_FRAMES];
        count_t             uses [MAX_FRAMES];
        logic [FAULT_W-1:0] faults;
        logic [FIU_W-1:0]   frames_reg;
        outcome_t           pending_outcomes [$];
        int unsigned        mismatches;
        int unsigned        hits_seen;
        int unsigned        evictions_seen;

        function new();
            for (int j = 0; j < MAX_FRAMES; j++) begin
                resident[j] = '0;
                occupied[j] = 1'b0;
                uses[j]     = '0;
            end
            faults     = '0;
            frames_reg = FIU_RESET;
            mismatches = 0;
            hits_seen  = 0;
            evictions_seen = 0;
        endfunction

        function void flag(string what, logic [FAULT_W-1:0] want, logic [FAULT_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        endfunction

        function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
            if (addr == ADDR_FRAMES_IN_USE)
                frames_reg = data[FIU_W-1:0];
        endfunction

        // 0 behaves as one frame, anything past the table as the full table
        function int active_count();
            if (frames_reg == 0)
                return 1;
            if (frames_reg > MAX_FRAMES)
                return MAX_FRAMES;
            return int'(frames_reg);
        endfunction

        function outcome_t predict_access(page_t page);
            outcome_t o;
            int       n;
            int       idx;
            bit       found;
            count_t   best;
            o     = '0;
            n     = active_count();
            idx   = 0;
            found = 1'b0;
            // hit search over the frames in use
            for (int j = 0; j < n; j++) begin
                if (!found && occupied[j] && resident[j] == page) begin
                    found = 1'b1;
                    idx   = j;
                end
            end
            if (found) begin
                if (uses[idx] != '1)
                    uses[idx]++;
                o.hit = 1'b1;
                hits_seen++;
            end else begin
                if (faults != FAULT_MAX)
                    faults++;
                // lowest empty frame first
                for (int j = 0; j < n; j++) begin
                    if (!found && !occupied[j]) begin
                        found = 1'b1;
                        idx   = j;
                    end
                end
                // else the lowest frame holding the smallest count
                if (!found) begin
                    best = uses[0];
                    idx  = 0;
                    for (int j = 1; j < n; j++) begin
                        if (uses[j] < best) begin
                            best = uses[j];
                            idx  = j;
                        end
                    end
                    o.evicted_valid = 1'b1;
                    o.evicted_page  = resident[idx];
                    evictions_seen++;
                end
                resident[idx] = page;
                occupied[idx] = 1'b1;
                uses[idx]     = 1;
            end
            o.slot        = idx[SLOT_W-1:0];
            o.fault_total = faults;
            return o;
        endfunction

        function void note_reference(page_t page);
            pending_outcomes.push_back(predict_access(page));
        endfunction

        function void check_outcome(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                flag("unexpected result word, fault_total", '0, got.fault_total);
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.hit !== want.hit)
                flag("hit", want.hit, got.hit);
            if (got.slot !== want.slot)
                flag("slot", want.slot, got.slot);
            if (got.evicted_valid !== want.evicted_valid)
                flag("evicted_valid", want.evicted_valid, got.evicted_valid);
            if (got.evicted_page !== want.evicted_page)
                flag("evicted_page", want.evicted_page, got.evicted_page);
            if (got.fault_total !== want.fault_total)
                flag("fault_total", want.fault_total, got.fault_total);
        endfunction

        function void check_register(logic [APB_DW-1:0] got);
            logic [APB_DW-1:0] want;
            want = '0;
            want[FIU_W-1:0] = frames_reg;
            if (got !== want)
                flag("frames_in_use readback", want, got);
        endfunction

        function void close_out();
            while (pending_outcomes.size() != 0) begin
                void'(pending_outcomes.pop_front());
                flag("missing result word, count", 1, 0);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    page_t                i_page_number = '0;
    logic                 o_valid;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_evicted_valid;
    page_t                o_evicted_page;
    logic [FAULT_W-1:0]   o_fault_total;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    lfu_ref_tracker tracker = new();
    longint      cycles = 0;
    int unsigned refs_taken = 0;
    int unsigned settings_done = 0;
    int          burst_left = 0;

    lfu_page_replacement_top #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("lfu_page_replacement_top_test NOT OK");
            $finish;
        end
    end

    // result check first, then the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.check_outcome({o_hit, o_slot, o_evicted_valid, o_evicted_page,
                                       o_fault_total});
            if (start && !busy) begin
                tracker.note_reference(i_page_number);
                refs_taken++;
            end
        end
    end

    // bursts of back-to-back words with random gaps between them
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        return $urandom_range(1, 15);
    endfunction

    // present one word and hold it until taken; start stays up when gap is 0
    task automatic send_page(page_t page, int gap);
        start         <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start         <= 1'b0;
            i_page_number <= page_t'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        if (start) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (tracker.pending_outcomes.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(logic [APB_AW-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.check_register(prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits are random, only the low nibble is kept
    task automatic configure(logic [FIU_W-1:0] value);
        logic [APB_DW-1:0] data;
        data = $urandom;
        data[FIU_W-1:0] = value;
        wait_drained();
        apb_write(ADDR_FRAMES_IN_USE, data);
        apb_read_check(ADDR_FRAMES_IN_USE);
        settings_done++;
    endtask

    task automatic send_list(page_t pages[]);
        foreach (pages[k])
            send_page(pages[k], next_gap());
    endtask

    // pages mostly from a small pool so hits and evictions both happen
    task automatic random_phase(logic [FIU_W-1:0] setting, int count);
        page_t pool[$];
        int    span;
        page_t page;
        configure(setting);
        span = tracker.active_count() + $urandom_range(1, 4);
        for (int k = 0; k < span; k++)
            pool.push_back(page_t'($urandom));
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0)
                page = page_t'($urandom);
            else
                page = pool[$urandom_range(0, span - 1)];
            send_page(page, next_gap());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: fill all eight frames, extremes of the page field, ties
        send_list('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                    16'h0001, 16'h8000, 16'h7FFF, 16'h1234, 16'h4321, 16'h5555,
                    16'h4321});

        // zero acts as one frame; frames above it are not searched
        configure(4'd0);
        send_list('{16'hBEEF, 16'hFFFF});

        // values above the table act as the full table; old frames hit again
        configure(4'd15);
        send_list('{16'hFFFF, 16'h0000});

        // write to a register that does not exist leaves the count alone
        wait_drained();
        apb_write(ADDR_UNMAPPED, 32'h0000_0003);
        apb_read_check(ADDR_FRAMES_IN_USE);
        send_list('{16'h1234, 16'h0F0F});

        configure(4'd3);
        send_list('{16'h3C3C, 16'hC3C3});

        // narrow to one frame and widen again; the outer frame keeps its page
        configure(4'd1);
        send_list('{16'h0F0F, 16'h0F0F});
        configure(4'd2);
        send_list('{16'h1111, 16'h2222, 16'h0F0F});

        // random part, a new frame setting per phase; frame contents carry over
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: random_phase(4'd1, PHASE_REFS);
                1: random_phase(4'd8, PHASE_REFS);
                2: random_phase(4'd0, PHASE_REFS);
                3: random_phase(4'd15, PHASE_REFS);
                default: random_phase(4'($urandom_range(1, 8)), PHASE_REFS);
            endcase
        end

        // drain and make sure nothing else shows up
        wait_drained();
        repeat (2 * WORD_CYCLES) @(posedge i_clk);
        tracker.close_out();

        $display("covered %0d page references (%0d hits, %0d evictions) over %0d frame settings,",
                 refs_taken, tracker.hits_seen, tracker.evictions_seen, settings_done);
        $display("including out-of-range frame counts and an unmapped register write");
        if (tracker.mismatches == 0)
            $display("lfu_page_replacement_top_test OK");
        else
            $display("lfu_page_replacement_top_test NOT OK");
        $finish;
    end

endmodule

FILE: lfu_page_replacement_top.f
sv/lfu_pkg.sv
sv/lfu_cell.sv
sv/lfu_page_replacement_top.sv
sv/lfu_checker.sv
bench/lfu_page_replacement_top_test.sv
